### rtl/pstt_pkg.sv
// ----------------------------------------------------------------------------
// pstt_pkg
// Types and constants for the position step block: request and result
// layouts, item kinds, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package pstt_pkg;

    // item kinds
    localparam logic [1:0] KIND_TARGET = 2'd0;
    localparam logic [1:0] KIND_COURSE = 2'd1;
    localparam logic [1:0] KIND_LOAD   = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic [30:0]        speed;
        logic signed [31:0] course_deg;
    } pstt_req_t;

    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic               at_target;
    } pstt_rsp_t;

    // degrees in Q15.16
    localparam logic [31:0] Q16_360 = 32'd23592960;
    localparam logic [31:0] Q16_180 = 32'd11796480;
    localparam logic [31:0] Q16_90  = 32'd5898240;

    // pi/180 and 1/K in Q2.30
    localparam logic [31:0] DEG_TO_RAD_Q30      = 32'd18740330;
    localparam logic [31:0] CORDIC_INV_GAIN_Q30 = 32'd652032874;

    // atan(2^-i) in Q2.30
    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8,
        32'd4,         32'd2,         32'd1,         32'd0
    };

endpackage

### rtl/position_step_toward_target_top.sv
// ----------------------------------------------------------------------------
// position_step_toward_target_top
// 2-D Q15.16 position that steps toward a target, along a compass course,
// or is loaded, using one shared multiplier and a small add/compare datapath.
// ----------------------------------------------------------------------------
// steps: load, unused kind or target at position go straight to the result;
//   a target step forms sums of squares, then unless within reach a 32-step
//   square root and two 31-step divisions; a course step rotates by CORDIC
// flow: one request at a time, the next accepted in the cycle after the
//   result is posted; posting waits while the previous result is unread
// reset: synchronous active-low aresetn clears the position to zero
module position_step_toward_target_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pstt_pkg::pstt_req_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pstt_pkg::pstt_rsp_t m_data
);
    import pstt_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_DIFF = 5'd1;
    localparam logic [4:0] ST_SQ   = 5'd2;
    localparam logic [4:0] ST_SQ2  = 5'd3;
    localparam logic [4:0] ST_SQRT = 5'd4;
    localparam logic [4:0] ST_MULS = 5'd5;
    localparam logic [4:0] ST_DVLD = 5'd6;
    localparam logic [4:0] ST_DIV  = 5'd7;
    localparam logic [4:0] ST_MOD  = 5'd8;
    localparam logic [4:0] ST_FOLD = 5'd9;
    localparam logic [4:0] ST_RAD  = 5'd10;
    localparam logic [4:0] ST_ZLD  = 5'd11;
    localparam logic [4:0] ST_ROT  = 5'd12;
    localparam logic [4:0] ST_SCL  = 5'd13;
    localparam logic [4:0] ST_ADD  = 5'd14;
    localparam logic [4:0] ST_FIN  = 5'd15;

    localparam logic [5:0] ROT_LAST = 6'(CORDIC_STEPS - 1);

    logic [4:0]         state_reg;
    pstt_req_t          req_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic [32:0]        ax_reg, ay_reg;
    logic               dxn_reg, dyn_reg;
    logic [30:0]        axs_reg, ays_reg;
    logic [63:0]        prod_reg, acc_reg, root_reg, bit_reg, rem_reg;
    logic [62:0]        dsh_reg;
    logic [30:0]        quo_reg;
    logic signed [33:0] stx_reg, sty_reg;
    logic [31:0]        mag_reg;
    logic [22:0]        rabs_reg;
    logic               rneg_reg, fneg_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic [5:0]         cnt_reg;
    logic               second_reg;
    logic               m_valid_reg;
    pstt_rsp_t          m_data_reg;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647)       return 32'sh7fffffff;
        else if (v < -34'sd2147483648) return 32'sh80000000;
        else                           return v[31:0];
    endfunction

    // rounded Q2.30 product back to Q15.16 magnitude
    function automatic logic signed [33:0] rnd30(input logic [63:0] p);
        logic [63:0] t;
        t = (p + 64'd536870912) >> 30;
        return $signed({1'b0, t[32:0]});
    endfunction

    // shared multiplier operand select
    logic [31:0] mul_a, mul_b;
    logic [33:0] cy_abs, cx_abs;
    assign cy_abs = cy_reg[33] ? 34'(-cy_reg) : 34'(cy_reg);
    assign cx_abs = cx_reg[33] ? 34'(-cx_reg) : 34'(cx_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQ: begin
                if (cnt_reg == 6'd0) begin
                    mul_a = ax_reg[31:0];
                    mul_b = ax_reg[31:0];
                end else if (cnt_reg == 6'd1) begin
                    mul_a = ay_reg[31:0];
                    mul_b = ay_reg[31:0];
                end else begin
                    mul_a = {1'b0, req_reg.speed};
                    mul_b = {1'b0, req_reg.speed};
                end
            end
            ST_SQ2: begin
                mul_a = (cnt_reg == 6'd0) ? {1'b0, axs_reg} : {1'b0, ays_reg};
                mul_b = mul_a;
            end
            ST_MULS: begin
                mul_a = {1'b0, req_reg.speed};
                mul_b = second_reg ? {1'b0, ays_reg} : {1'b0, axs_reg};
            end
            ST_RAD: begin
                mul_a = {9'b0, rabs_reg};
                mul_b = DEG_TO_RAD_Q30;
            end
            ST_SCL: begin
                mul_a = {1'b0, req_reg.speed};
                mul_b = (cnt_reg == 6'd0) ? cy_abs[31:0] : cx_abs[31:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // differences to target
    logic signed [32:0] dx, dy;
    assign dx = {req_reg.target_x[31], req_reg.target_x} - {pos_x_reg[31], pos_x_reg};
    assign dy = {req_reg.target_y[31], req_reg.target_y} - {pos_y_reg[31], pos_y_reg};

    // near check and pre-shift
    logic [32:0] m_max;
    logic [32:0] axs_full, ays_full;
    logic        near;
    assign m_max = (ax_reg > ay_reg) ? ax_reg : ay_reg;
    assign near  = (ax_reg <= {2'b0, req_reg.speed}) && (ay_reg <= {2'b0, req_reg.speed})
                   && (acc_reg <= prod_reg);
    always_comb begin
        if (m_max[32]) begin
            axs_full = ax_reg >> 2;
            ays_full = ay_reg >> 2;
        end else if (m_max[31]) begin
            axs_full = ax_reg >> 1;
            ays_full = ay_reg >> 1;
        end else begin
            axs_full = ax_reg;
            ays_full = ay_reg;
        end
    end

    // square root step
    logic [63:0] rb;
    logic        sq_ge;
    assign rb    = root_reg + bit_reg;
    assign sq_ge = acc_reg >= rb;

    // divide step
    logic        dv_ge;
    logic [30:0] q_next;
    logic signed [33:0] q_signed;
    assign dv_ge    = rem_reg >= {1'b0, dsh_reg};
    assign q_next   = {quo_reg[29:0], dv_ge};
    assign q_signed = $signed({3'b0, q_next});

    // modulo step
    logic [31:0] mod_sub;
    assign mod_sub = Q16_360 << cnt_reg[2:0];

    // fold course into [-90, 90]
    logic signed [32:0] r0, r1, r2;
    logic               fneg;
    always_comb begin
        r0   = req_reg.course_deg[31] ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
        r1   = r0;
        fneg = 1'b0;
        if (r0 > $signed({1'b0, Q16_180}))       r1 = r0 - $signed({1'b0, Q16_360});
        else if (r0 < -$signed({1'b0, Q16_180})) r1 = r0 + $signed({1'b0, Q16_360});
        r2 = r1;
        if (r1 > $signed({1'b0, Q16_90})) begin
            r2   = r1 - $signed({1'b0, Q16_180});
            fneg = 1'b1;
        end else if (r1 < -$signed({1'b0, Q16_90})) begin
            r2   = r1 + $signed({1'b0, Q16_180});
            fneg = 1'b1;
        end
    end
    logic [32:0] r2_abs;
    assign r2_abs = r2[32] ? 33'(-r2) : 33'(r2);

    // cordic rotation step
    logic signed [33:0] xs, ys, atan_v;
    logic [63:0]        zr;
    assign xs     = cx_reg >>> cnt_reg[4:0];
    assign ys     = cy_reg >>> cnt_reg[4:0];
    assign atan_v = $signed({2'b0, ATAN_Q30[cnt_reg[4:0]]});
    assign zr     = (prod_reg + 64'd32768) >> 16;

    logic signed [33:0] rnd_v;
    assign rnd_v = rnd30(prod_reg);

    // sequencer
    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a * mul_b);
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_FIN) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg   <= s_data;
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    ax_reg  <= dx[32] ? 33'(-dx) : 33'(dx);
                    ay_reg  <= dy[32] ? 33'(-dy) : 33'(dy);
                    dxn_reg <= dx[32];
                    dyn_reg <= dy[32];
                    cnt_reg <= '0;
                    unique case (req_reg.kind)
                        KIND_LOAD: begin
                            pos_x_reg <= req_reg.target_x;
                            pos_y_reg <= req_reg.target_y;
                            state_reg <= ST_FIN;
                        end
                        KIND_TARGET: begin
                            state_reg <= (dx == '0 && dy == '0) ? ST_FIN : ST_SQ;
                        end
                        KIND_COURSE: begin
                            mag_reg   <= req_reg.course_deg[31]
                                         ? 32'(-$signed({1'b1, req_reg.course_deg}))
                                         : req_reg.course_deg;
                            cnt_reg   <= 6'd6;
                            state_reg <= ST_MOD;
                        end
                        default: state_reg <= ST_FIN;
                    endcase
                end
                ST_SQ: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd1) acc_reg <= prod_reg;
                    if (cnt_reg == 6'd2) acc_reg <= acc_reg + prod_reg;
                    if (cnt_reg == 6'd3) begin
                        cnt_reg <= '0;
                        if (near) begin
                            pos_x_reg <= req_reg.target_x;
                            pos_y_reg <= req_reg.target_y;
                            state_reg <= ST_FIN;
                        end else begin
                            axs_reg   <= axs_full[30:0];
                            ays_reg   <= ays_full[30:0];
                            state_reg <= ST_SQ2;
                        end
                    end
                end
                ST_SQ2: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd1) acc_reg <= prod_reg;
                    if (cnt_reg == 6'd2) begin
                        acc_reg   <= acc_reg + prod_reg;
                        root_reg  <= '0;
                        bit_reg   <= 64'd1 << 62;
                        cnt_reg   <= '0;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (sq_ge) begin
                        acc_reg  <= acc_reg - rb;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31) begin
                        second_reg <= 1'b0;
                        state_reg  <= ST_MULS;
                    end
                end
                ST_MULS: state_reg <= ST_DVLD;
                ST_DVLD: begin
                    rem_reg   <= prod_reg;
                    dsh_reg   <= {1'b0, root_reg[31:0], 30'b0};
                    quo_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (dv_ge) rem_reg <= rem_reg - {1'b0, dsh_reg};
                    quo_reg <= q_next;
                    dsh_reg <= dsh_reg >> 1;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd30) begin
                        if (!second_reg) begin
                            stx_reg    <= dxn_reg ? -q_signed : q_signed;
                            second_reg <= 1'b1;
                            state_reg  <= ST_MULS;
                        end else begin
                            sty_reg   <= dyn_reg ? -q_signed : q_signed;
                            state_reg <= ST_ADD;
                        end
                    end
                end
                ST_MOD: begin
                    if (mag_reg >= mod_sub) mag_reg <= mag_reg - mod_sub;
                    if (cnt_reg == 6'd0) state_reg <= ST_FOLD;
                    else                 cnt_reg   <= cnt_reg - 6'd1;
                end
                ST_FOLD: begin
                    rabs_reg  <= r2_abs[22:0];
                    rneg_reg  <= r2[32];
                    fneg_reg  <= fneg;
                    state_reg <= ST_RAD;
                end
                ST_RAD: state_reg <= ST_ZLD;
                ST_ZLD: begin
                    cz_reg    <= rneg_reg ? -$signed({2'b0, zr[31:0]})
                                          : $signed({2'b0, zr[31:0]});
                    cx_reg    <= $signed({2'b0, CORDIC_INV_GAIN_Q30});
                    cy_reg    <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_ROT;
                end
                ST_ROT: begin
                    if (!cz_reg[33]) begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - atan_v;
                    end else begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + atan_v;
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == ROT_LAST) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SCL;
                    end
                end
                ST_SCL: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd1) begin
                        stx_reg <= (cy_reg[33] ^ fneg_reg) ? -rnd_v : rnd_v;
                    end
                    if (cnt_reg == 6'd2) begin
                        sty_reg   <= (cx_reg[33] ^ fneg_reg) ? -rnd_v : rnd_v;
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    pos_x_reg <= sat32({{2{pos_x_reg[31]}}, pos_x_reg} + stx_reg);
                    pos_y_reg <= sat32({{2{pos_y_reg[31]}}, pos_y_reg} + sty_reg);
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.new_x     <= pos_x_reg;
                        m_data_reg.new_y     <= pos_y_reg;
                        m_data_reg.at_target <= (pos_x_reg == req_reg.target_x)
                                                && (pos_y_reg == req_reg.target_y);
                        m_valid_reg          <= 1'b1;
                        state_reg            <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the position step block: a stimulus table of directed requests and
// a long random run with sender and receiver idling, each result compared
// field by field with its table entry, else a built-in fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import pstt_pkg::*;

    localparam int STEPS      = 16;
    localparam int RAND_ITEMS = 800;
    localparam int WATCHDOG   = 20000;
    localparam longint DEG360 = 64'd23592960;
    localparam longint DEG180 = 64'd11796480;
    localparam longint DEG90  = 64'd5898240;
    localparam longint RAD_PER_DEG = 64'd18740330;
    localparam longint INV_GAIN    = 64'd652032874;
    localparam logic [31:0] MAXP = 32'h7fffffff;
    localparam logic [31:0] MINN = 32'h80000000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    pstt_req_t s_data;
    logic      m_valid;
    logic      m_ready;
    pstt_rsp_t m_data;

    // directed row: expected result typed in only where obvious
    typedef struct {
        pstt_req_t req;
        bit        has_exp;
        pstt_rsp_t exp;
    } dir_row_t;

    pstt_rsp_t  expected_positions[$];
    logic signed [31:0] cur_x, cur_y;
    int         errors = 0;
    int         idle_cycles;
    int         send_idle_pct, recv_idle_pct;
    dir_row_t   dir_rows[$];

    position_step_toward_target_top #(.CORDIC_STEPS(STEPS)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic longint sat_q16(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint trig_times_speed(longint trig, longint unsigned spd);
        longint unsigned mag;
        longint r;
        mag = (trig < 0 ? -trig : trig) * spd;
        r = (mag + (64'd1 << 29)) >> 30;
        return trig < 0 ? -r : r;
    endfunction

    // advance the tracked position by one request, return the result
    function automatic pstt_rsp_t predict_position(pstt_req_t req);
        longint tx, ty, spd, dx, dy, r, x, y, z, xs, ys, sx, sy;
        longint unsigned ax, ay, m, root_len, mag;
        bit neg;
        int s;
        pstt_rsp_t res;
        tx = req.target_x;
        ty = req.target_y;
        spd = longint'(req.speed);
        if (req.kind == KIND_TARGET) begin
            dx = tx - cur_x;
            dy = ty - cur_y;
            if (dx != 0 || dy != 0) begin
                ax = dx < 0 ? -dx : dx;
                ay = dy < 0 ? -dy : dy;
                if (ax <= spd && ay <= spd && ax * ax + ay * ay <= spd * spd) begin
                    cur_x = 32'(tx);
                    cur_y = 32'(ty);
                end else begin
                    m = ax > ay ? ax : ay;
                    s = 0;
                    while ((m >> s) >= (64'd1 << 31)) s++;
                    ax >>= s;
                    ay >>= s;
                    root_len = isqrt(ax * ax + ay * ay);
                    if (root_len != 0) begin
                        sx = (spd * ax) / root_len;
                        sy = (spd * ay) / root_len;
                        cur_x = 32'(sat_q16(longint'(cur_x) + (dx < 0 ? -sx : sx)));
                        cur_y = 32'(sat_q16(longint'(cur_y) + (dy < 0 ? -sy : sy)));
                    end
                end
            end
        end else if (req.kind == KIND_COURSE) begin
            // fold course into [-90, 90] degrees
            r = longint'(req.course_deg) % DEG360;
            neg = 0;
            if (r > DEG180) r -= DEG360;
            else if (r < -DEG180) r += DEG360;
            if (r > DEG90) begin
                r -= DEG180;
                neg = 1;
            end else if (r < -DEG90) begin
                r += DEG180;
                neg = 1;
            end
            mag = (r < 0 ? -r : r) * RAD_PER_DEG;
            z = (mag + (64'd1 << 15)) >> 16;
            if (r < 0) z = -z;
            x = INV_GAIN;
            y = 0;
            // cordic rotation
            for (int i = 0; i < STEPS && i < 32; i++) begin
                xs = fshift(x, i);
                ys = fshift(y, i);
                if (z >= 0) begin
                    x -= ys; y += xs; z -= longint'(ATAN_Q30[i]);
                end else begin
                    x += ys; y -= xs; z += longint'(ATAN_Q30[i]);
                end
            end
            dx = trig_times_speed(y, spd);
            dy = trig_times_speed(x, spd);
            if (neg) begin
                dx = -dx;
                dy = -dy;
            end
            cur_x = 32'(sat_q16(longint'(cur_x) + dx));
            cur_y = 32'(sat_q16(longint'(cur_y) + dy));
        end else if (req.kind == KIND_LOAD) begin
            cur_x = req.target_x;
            cur_y = req.target_y;
        end
        res.new_x = cur_x;
        res.new_y = cur_y;
        res.at_target = (cur_x == req.target_x) && (cur_y == req.target_y);
        return res;
    endfunction

    function automatic pstt_req_t mk_req(logic [1:0] k, logic [31:0] tx, logic [31:0] ty,
                                         logic [30:0] spd, logic [31:0] crs);
        pstt_req_t r;
        r.kind = k; r.target_x = tx; r.target_y = ty; r.speed = spd; r.course_deg = crs;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return MAXP;
            1: return MINN;
            2: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_speed();
        case ($urandom_range(0, 5))
            0: return 31'h7fffffff;
            1: return 31'd0;
            2: return 31'($urandom_range(0, 32'h003fffff));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic pstt_req_t rand_req();
        logic [1:0] k;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45) k = KIND_TARGET;
        else if (sel < 80) k = KIND_COURSE;
        else if (sel < 96) k = KIND_LOAD;
        else k = 2'd3;
        return mk_req(k, rand_word(), rand_word(), rand_speed(),
                      ($urandom_range(0, 1)) ? $urandom : rand_word());
    endfunction

    function automatic void add_row(pstt_req_t req, int has_exp, logic [31:0] ex,
                                    logic [31:0] ey, int at);
        dir_row_t row;
        row.req = req;
        row.has_exp = (has_exp != 0);
        row.exp.new_x = ex;
        row.exp.new_y = ey;
        row.exp.at_target = (at != 0);
        dir_rows.push_back(row);
    endfunction

    // hand one request to the block, holding it until accepted
    task automatic send_request(pstt_req_t req);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // receiver stalls and result checking
    always @(posedge aclk) begin
        pstt_rsp_t exp_rsp;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_positions.size() == 0) begin
                    $error("result with no request outstanding: %h", m_data);
                    errors++;
                end else begin
                    exp_rsp = expected_positions.pop_front();
                    if (m_data.new_x !== exp_rsp.new_x) begin
                        $error("new_x expected %0d actual %0d", exp_rsp.new_x, m_data.new_x);
                        errors++;
                    end
                    if (m_data.new_y !== exp_rsp.new_y) begin
                        $error("new_y expected %0d actual %0d", exp_rsp.new_y, m_data.new_y);
                        errors++;
                    end
                    if (m_data.at_target !== exp_rsp.at_target) begin
                        $error("at_target expected %0d actual %0d",
                               exp_rsp.at_target, m_data.at_target);
                        errors++;
                    end
                end
            end
            m_ready <= !(recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        pstt_req_t req;
        pstt_rsp_t exp_rsp;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cur_x = 0;
        cur_y = 0;

        // directed table
        add_row(mk_req(KIND_TARGET, 0, 0, 31'd65536, 0), 1, 0, 0, 1);
        add_row(mk_req(KIND_TARGET, 32'd65536, 0, 31'd0, 0), 1, 0, 0, 0);
        add_row(mk_req(KIND_TARGET, 32'd65536, 32'd65536, 31'd196608, 0), 1,
                32'd65536, 32'd65536, 1);
        add_row(mk_req(KIND_LOAD, MAXP, MINN, 31'd0, 0), 1, MAXP, MINN, 1);
        add_row(mk_req(KIND_TARGET, MINN, MAXP, 31'h7fffffff, 0), 0, 0, 0, 0);
        add_row(mk_req(KIND_LOAD, MAXP, MAXP, 31'd0, 0), 1, MAXP, MAXP, 1);
        add_row(mk_req(KIND_COURSE, 0, 0, 31'h7fffffff, 32'd2949120), 1,
                MAXP, MAXP, 0);
        add_row(mk_req(KIND_LOAD, MINN, MINN, 31'd0, 0), 1, MINN, MINN, 1);
        add_row(mk_req(KIND_COURSE, 0, 0, 31'h7fffffff, 32'hffd30000), 0,
                0, 0, 0);
        add_row(mk_req(KIND_LOAD, 0, 0, 31'd0, 0), 1, 0, 0, 1);
        add_row(mk_req(KIND_COURSE, 1, 1, 31'd65536, 0), 0, 0, 0, 0);
        add_row(mk_req(KIND_COURSE, 0, 0, 31'd65536, 32'd11796480), 0, 0, 0, 0);
        add_row(mk_req(KIND_COURSE, 0, 0, 31'd65536, 32'd23592960), 0, 0, 0, 0);
        add_row(mk_req(KIND_COURSE, 0, 0, 31'd65536, 32'hff4c0000), 0, 0, 0, 0);
        add_row(mk_req(KIND_COURSE, 0, 0, 31'd65536, MAXP), 0, 0, 0, 0);
        add_row(mk_req(KIND_COURSE, 0, 0, 31'd65536, MINN), 0, 0, 0, 0);
        add_row(mk_req(KIND_COURSE, 0, 0, 31'd0, 32'd100), 0, 0, 0, 0);
        add_row(mk_req(2'd3, 32'd5, 32'd7, 31'd9, 32'd11), 0, 0, 0, 0);
        add_row(mk_req(KIND_TARGET, 32'd40000000, 32'hfd000000, 31'd1000000, 0), 0,
                0, 0, 0);
        add_row(mk_req(KIND_TARGET, 32'd3, 32'd4, 31'd5, 0), 0, 0, 0, 0);
        add_row(mk_req(KIND_LOAD, 32'hffffffff, 32'hffffffff, 31'h7fffffff, 32'hffffffff),
                1, 32'hffffffff, 32'hffffffff, 1);
        add_row(mk_req(2'd3, 32'hffffffff, 32'hffffffff, 31'd0, 0), 1,
                32'hffffffff, 32'hffffffff, 1);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        m_ready <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            exp_rsp = predict_position(dir_rows[i].req);
            if (dir_rows[i].has_exp && exp_rsp !== dir_rows[i].exp)
                $display("note: predictor differs from table row %0d", i);
            expected_positions.push_back(dir_rows[i].has_exp ? dir_rows[i].exp : exp_rsp);
            send_request(dir_rows[i].req);
        end

        // random phases with different idling
        for (int n = 0; n < RAND_ITEMS; n++) begin
            case ((n * 5) / RAND_ITEMS)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 62; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 62; end
                3: begin send_idle_pct = 10; recv_idle_pct = 10; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            req = rand_req();
            // pull some targets near the position so they get reached
            if (req.kind == KIND_TARGET && $urandom_range(0, 3) == 0) begin
                req.target_x = cur_x + ($urandom_range(0, 4000) - 2000);
                req.target_y = cur_y + ($urandom_range(0, 4000) - 2000);
            end
            expected_positions.push_back(predict_position(req));
            send_request(req);
        end
        s_valid <= 1'b0;

        while (expected_positions.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
